FILE: hw/rtl/pnc_pkg.sv
// ----------------------------------------------------------------------------
// pnc_pkg
// Shared types, constants and helpers of the nearest palette color remap.
// ----------------------------------------------------------------------------
package pnc_pkg;

  localparam int PalDepth = 16;
  localparam int IdxW     = (PalDepth > 1) ? $clog2(PalDepth) : 1;
  localparam int TreeW    = 1 << IdxW;

  localparam int CmdW   = 2;
  localparam int EntryW = 4;
  localparam int CompW  = 16;
  localparam int ChanW  = 8;
  localparam int FracW  = 4;
  localparam int PixW   = 3 * ChanW;
  localparam int MatchW = 4;
  localparam int SizeW  = 5;

  localparam int DiffW = CompW + 1;
  localparam int MagW  = CompW;
  localparam int SqW   = 2 * MagW;
  localparam int DistW = SqW + 2;

  typedef enum logic [CmdW-1:0] {
    CMD_TGT = 2'd0,
    CMD_SRC = 2'd1,
    CMD_PIX = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]          command;
    logic [EntryW-1:0]        entry_index;
    logic signed [CompW-1:0]  comp_one;
    logic signed [CompW-1:0]  comp_two;
    logic signed [CompW-1:0]  comp_three;
    logic [PixW-1:0]          pixel_in;
    logic                     last_pixel;
  } in_word_t;

  typedef struct packed {
    logic [PixW-1:0]   pixel_out;
    logic [MatchW-1:0] match_index;
    logic              last_out;
  } out_word_t;

  // word in flight plus its decoded kind
  typedef struct packed {
    cmd_e     kind;
    in_word_t w;
  } pipe_t;

  // palette entry, component one in slot 0
  typedef logic [2:0][CompW-1:0] entry_t;

  typedef struct packed {
    logic             ok;
    logic [IdxW-1:0]  idx;
    logic [DistW-1:0] dsq;
  } cand_t;

  // round half up, clamp to 0..255
  function automatic logic [ChanW-1:0] to_byte(input logic [CompW-1:0] v);
    logic signed [CompW:0]  r;
    logic [CompW-FracW:0]   q;
    r = (CompW+1)'($signed(v)) + (CompW+1)'(1 << (FracW - 1));
    q = r[CompW:FracW];
    if (r[CompW]) begin
      return '0;
    end else if (q > (CompW-FracW+1)'((1 << ChanW) - 1)) begin
      return '1;
    end else begin
      return q[ChanW-1:0];
    end
  endfunction

  // lower index wins a tie
  function automatic cand_t pick(input cand_t a, input cand_t b);
    if (b.ok && (!a.ok || (b.dsq < a.dsq))) begin
      return b;
    end else begin
      return a;
    end
  endfunction

endpackage

FILE: hw/rtl/pnc_dist.sv
// ----------------------------------------------------------------------------
// pnc_dist
// Target palette store and three-stage squared distance lanes.
// ----------------------------------------------------------------------------
module pnc_dist import pnc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  pipe_t            s0_i,
  output pipe_t            pipe_o,
  output logic [DistW-1:0] dist_o [PalDepth]
);

  entry_t           tgt_q  [PalDepth];
  logic [MagW-1:0]  mag_d  [PalDepth][3];
  logic [MagW-1:0]  mag_q  [PalDepth][3];
  logic [SqW-1:0]   sq_q   [PalDepth][3];
  logic [DistW-1:0] dist_q [PalDepth];
  pipe_t            p1_q, p2_q, p3_q;

  // target entries are written when a load word leaves stage 0
  always_ff @(posedge clk_i) begin
    if (en_i && (s0_i.kind == CMD_TGT) && (int'(s0_i.w.entry_index) < PalDepth)) begin
      tgt_q[IdxW'(s0_i.w.entry_index)] <= {s0_i.w.comp_three, s0_i.w.comp_two,
                                           s0_i.w.comp_one};
    end
  end

  always_comb begin
    logic [ChanW-1:0]        ch;
    logic signed [DiffW-1:0] d;
    for (int i = 0; i < PalDepth; i++) begin
      for (int c = 0; c < 3; c++) begin
        ch = s0_i.w.pixel_in[PixW-1-ChanW*c -: ChanW];
        d  = DiffW'($signed({1'b0, ch, {FracW{1'b0}}})) - DiffW'($signed(tgt_q[i][c]));
        mag_d[i][c] = d[DiffW-1] ? MagW'(-d) : MagW'(d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < PalDepth; i++) begin
        for (int c = 0; c < 3; c++) begin
          mag_q[i][c] <= mag_d[i][c];
          sq_q[i][c]  <= SqW'(mag_q[i][c]) * SqW'(mag_q[i][c]);
        end
        dist_q[i] <= DistW'(sq_q[i][0]) + DistW'(sq_q[i][1]) + DistW'(sq_q[i][2]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q <= '{kind: CMD_NOP, w: '0};
      p2_q <= '{kind: CMD_NOP, w: '0};
      p3_q <= '{kind: CMD_NOP, w: '0};
    end else if (en_i) begin
      p1_q <= s0_i;
      p2_q <= p1_q;
      p3_q <= p2_q;
    end
  end

  assign pipe_o = p3_q;
  assign dist_o = dist_q;

endmodule

FILE: hw/rtl/pnc_tree.sv
// ----------------------------------------------------------------------------
// pnc_tree
// Registered minimum tree over the distance lanes, one level per stage.
// ----------------------------------------------------------------------------
module pnc_tree import pnc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [SizeW-1:0] size_i,
  input  pipe_t            pipe_i,
  input  logic [DistW-1:0] dist_i [PalDepth],
  output pipe_t            pipe_o,
  output logic [IdxW-1:0]  best_o
);

  cand_t node_q [1:TreeW-1];
  cand_t all_c  [1:2*TreeW-1];
  pipe_t pipe_q [IdxW];

  for (genvar l = 0; l < TreeW; l++) begin : g_leaf
    if (l < PalDepth) begin : g_lane
      assign all_c[TreeW+l] = '{ok:   (l == 0) || (l < int'(size_i)),
                                idx:  IdxW'(l),
                                dsq:  dist_i[l]};
    end else begin : g_pad
      assign all_c[TreeW+l] = '{ok: 1'b0, idx: IdxW'(l), dsq: '0};
    end
  end

  for (genvar n = 1; n < TreeW; n++) begin : g_node
    assign all_c[n] = node_q[n];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int n = 1; n < TreeW; n++) begin
        node_q[n] <= pick(all_c[2*n], all_c[2*n+1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < IdxW; k++) begin
        pipe_q[k] <= '{kind: CMD_NOP, w: '0};
      end
    end else if (en_i) begin
      pipe_q[0] <= pipe_i;
      for (int k = 1; k < IdxW; k++) begin
        pipe_q[k] <= pipe_q[k-1];
      end
    end
  end

  assign pipe_o = pipe_q[IdxW-1];
  assign best_o = all_c[1].idx;

endmodule

FILE: hw/rtl/pnc_remap.sv
// ----------------------------------------------------------------------------
// pnc_remap
// Source palette store, rounding and clamping, output register.
// ----------------------------------------------------------------------------
module pnc_remap import pnc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  pipe_t           pipe_i,
  input  logic [IdxW-1:0] best_i,
  output logic            out_valid_o,
  output out_word_t       out_word_o
);

  entry_t    src_q [PalDepth];
  entry_t    sel;
  logic      out_valid_q;
  out_word_t out_word_q;

  // source entries are written when a load word reaches this stage
  always_ff @(posedge clk_i) begin
    if (en_i && (pipe_i.kind == CMD_SRC) && (int'(pipe_i.w.entry_index) < PalDepth)) begin
      src_q[IdxW'(pipe_i.w.entry_index)] <= {pipe_i.w.comp_three, pipe_i.w.comp_two,
                                             pipe_i.w.comp_one};
    end
  end

  assign sel = src_q[best_i];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_word_q.pixel_out   <= {to_byte(sel[0]), to_byte(sel[1]), to_byte(sel[2])};
      out_word_q.match_index <= MatchW'(best_i);
      out_word_q.last_out    <= pipe_i.w.last_pixel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= (pipe_i.kind == CMD_PIX);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: hw/rtl/palette_nearest_color_remap.sv
// ----------------------------------------------------------------------------
// palette_nearest_color_remap
// Result path: input register, distance stages, minimum tree levels, output register.
// Throughput: one word per cycle; the whole pipe holds while the output waits.
// Load words take pipe slots and write the palettes in order, no result.
// Reset clears all valid state and sets palette size to 1; palettes undefined.
// ----------------------------------------------------------------------------
module palette_nearest_color_remap import pnc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_word_t         in_word_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_word_t        out_word_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [SizeW-1:0] cfg_data_i
);

  logic             en;
  logic [SizeW-1:0] size_q;
  pipe_t            s0_q;
  pipe_t            dist_pipe;
  pipe_t            root_pipe;
  logic [DistW-1:0] lane_dist [PalDepth];
  logic [IdxW-1:0]  best;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeW'(1);
    end else if (cfg_valid_i) begin
      size_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '{kind: CMD_NOP, w: '0};
    end else if (en) begin
      s0_q <= '{kind: in_valid_i ? cmd_e'(in_word_i.command) : CMD_NOP, w: in_word_i};
    end
  end

  pnc_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .s0_i   (s0_q),
    .pipe_o (dist_pipe),
    .dist_o (lane_dist)
  );

  pnc_tree u_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .size_i (size_q),
    .pipe_i (dist_pipe),
    .dist_i (lane_dist),
    .pipe_o (root_pipe),
    .best_o (best)
  );

  pnc_remap u_remap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .pipe_i      (root_pipe),
    .best_i      (best),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  a_match_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.match_index == '0) ||
                    (SizeW'(out_word_o.match_index) < size_q))
    else $error("match index outside searched palette");

  a_result_from_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(root_pipe.kind == CMD_PIX))
    else $error("result word without a pixel word");

  a_stall_holds_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(s0_q))
    else $error("front stage moved during stall");

endmodule

FILE: verif/palette_nearest_color_remap_tb.sv
// ----------------------------------------------------------------------------
// palette_nearest_color_remap_tb
// Self-checking bench for the nearest palette color remap. Palette loads and
// pixel words go in through the valid/ready input channel. A predictor in the
// bench tracks both palettes and the palette size, and queues the expected
// remapped word for each accepted pixel. Directed tests cover reset size,
// rounding and clamping, zero size and tie breaks. Random phases follow, with
// several palette sizes and idling on either side, plus a long output hold.
// ----------------------------------------------------------------------------
module palette_nearest_color_remap_tb;
  import pnc_pkg::*;

  localparam int DrainCycles = 24;
  localparam int CycleLimit  = 200000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_word_t         in_word = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_word;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [SizeW-1:0] cfg_data = '0;

  // predictor state
  logic signed [CompW-1:0] tgt_pal [PalDepth][3];
  logic signed [CompW-1:0] src_pal [PalDepth][3];
  bit                      tgt_loaded [PalDepth];
  bit                      src_loaded [PalDepth];
  int                      pal_size = 1;
  out_word_t               remapped_q [$];

  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          rx_hold_left = 0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;

  palette_nearest_color_remap dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("palette_nearest_color_remap_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int entries_searched();
    if (pal_size == 0) begin
      return 1;
    end else if (pal_size > PalDepth) begin
      return PalDepth;
    end
    return pal_size;
  endfunction

  function automatic logic [ChanW-1:0] round_clamp(input logic signed [CompW-1:0] v);
    int r;
    r = int'(v) + (1 << (FracW - 1));
    if (r < 0) begin
      return '0;
    end
    r = r >>> FracW;
    if (r > 255) begin
      return '1;
    end
    return ChanW'(r);
  endfunction

  function automatic out_word_t nearest_remap(input logic [PixW-1:0] pix, input logic last);
    longint    chan [3];
    longint    dlt;
    longint    dsq;
    longint    best_dsq;
    int        best;
    int        n;
    out_word_t r;
    chan[0] = longint'(pix[2*ChanW +: ChanW]) << FracW;
    chan[1] = longint'(pix[ChanW +: ChanW]) << FracW;
    chan[2] = longint'(pix[0 +: ChanW]) << FracW;
    n = entries_searched();
    best = 0;
    best_dsq = 0;
    for (int i = 0; i < n; i++) begin
      dsq = 0;
      for (int c = 0; c < 3; c++) begin
        dlt = chan[c] - longint'(tgt_pal[i][c]);
        dsq += dlt * dlt;
      end
      if (i == 0 || dsq < best_dsq) begin
        best_dsq = dsq;
        best = i;
      end
    end
    r.pixel_out = {round_clamp(src_pal[best][0]), round_clamp(src_pal[best][1]),
                   round_clamp(src_pal[best][2])};
    r.match_index = MatchW'(best);
    r.last_out = last;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [CompW-1:0] pick_comp();
    case ($urandom_range(0, 9))
      0, 1, 2: return CompW'($urandom_range(0, 4095));
      3:       return CompW'($urandom);
      4: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh8000;
          1:       return 16'sh7fff;
          2:       return '0;
          default: return '1;
        endcase
      end
      5, 6:    return CompW'($urandom_range(0, 15) * 256);
      7:       return CompW'(int'($urandom_range(0, 40)) - 20);
      default: return CompW'($urandom_range(0, 255) << FracW);
    endcase
  endfunction

  function automatic logic [ChanW-1:0] near_chan(input logic signed [CompW-1:0] c);
    int v;
    v = (int'(c) >>> FracW) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) begin
      return '0;
    end else if (v > 255) begin
      return '1;
    end
    return ChanW'(v);
  endfunction

  // unused fields carry random content
  function automatic in_word_t junk_word();
    in_word_t w;
    w.command     = CMD_NOP;
    w.entry_index = EntryW'($urandom);
    w.comp_one    = CompW'($urandom);
    w.comp_two    = CompW'($urandom);
    w.comp_three  = CompW'($urandom);
    w.pixel_in    = PixW'($urandom);
    w.last_pixel  = 1'($urandom);
    return w;
  endfunction

  function automatic in_word_t load_word(input cmd_e cmd, input int idx,
                                         input int a, input int b, input int c);
    in_word_t w;
    w = junk_word();
    w.command     = cmd;
    w.entry_index = EntryW'(idx);
    w.comp_one    = CompW'(a);
    w.comp_two    = CompW'(b);
    w.comp_three  = CompW'(c);
    return w;
  endfunction

  function automatic in_word_t pixel_word(input logic [PixW-1:0] pix, input logic last);
    in_word_t w;
    w = junk_word();
    w.command    = CMD_PIX;
    w.pixel_in   = pix;
    w.last_pixel = last;
    return w;
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int       roll;
    int       n;
    int       slot;
    bit       has_gap;
    cmd_e     gap_cmd;
    int       gap_idx;
    w = junk_word();
    n = entries_searched();
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      w.command = CMD_TGT;
    end else if (roll < 24) begin
      w.command = CMD_SRC;
    end else if (roll < 27) begin
      w.command = CMD_NOP;
    end else begin
      w.command = CMD_PIX;
    end
    has_gap = 1'b0;
    gap_cmd = CMD_TGT;
    gap_idx = 0;
    for (int i = n - 1; i >= 0; i--) begin
      if (!tgt_loaded[i]) begin
        has_gap = 1'b1;
        gap_cmd = CMD_TGT;
        gap_idx = i;
      end else if (!src_loaded[i]) begin
        has_gap = 1'b1;
        gap_cmd = CMD_SRC;
        gap_idx = i;
      end
    end
    // never search an entry that was not loaded
    if (w.command == CMD_PIX && has_gap) begin
      w.command = gap_cmd;
      w.entry_index = EntryW'(gap_idx);
    end
    if (w.command == CMD_TGT || w.command == CMD_SRC) begin
      w.comp_one   = pick_comp();
      w.comp_two   = pick_comp();
      w.comp_three = pick_comp();
    end else if (w.command == CMD_PIX) begin
      roll = $urandom_range(0, 9);
      if (roll < 4) begin
        slot = $urandom_range(0, n - 1);
        w.pixel_in = {near_chan(tgt_pal[slot][0]), near_chan(tgt_pal[slot][1]),
                      near_chan(tgt_pal[slot][2])};
      end else if (roll < 6) begin
        w.pixel_in = {ChanW'($urandom_range(0, 15) * 16), ChanW'($urandom_range(0, 15) * 16),
                      ChanW'($urandom_range(0, 15) * 16)};
      end
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    case (w.command)
      CMD_TGT: begin
        tgt_pal[w.entry_index] = '{w.comp_one, w.comp_two, w.comp_three};
        tgt_loaded[w.entry_index] = 1'b1;
      end
      CMD_SRC: begin
        src_pal[w.entry_index] = '{w.comp_one, w.comp_two, w.comp_three};
        src_loaded[w.entry_index] = 1'b1;
      end
      CMD_PIX: remapped_q.push_back(nearest_remap(w.pixel_in, w.last_pixel));
      default: ;
    endcase
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (remapped_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_size(input int v);
    wait_drain();
    // load and idle words give no result but may still be in the pipe
    repeat (DrainCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= SizeW'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pal_size = v;
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (remapped_q.size() == 0) begin
        report_mismatch("word with nothing pending", out_word, 0);
      end else begin
        want = remapped_q.pop_front();
        if (out_word.pixel_out !== want.pixel_out) begin
          report_mismatch("pixel_out", out_word.pixel_out, want.pixel_out);
        end
        if (out_word.match_index !== want.match_index) begin
          report_mismatch("match_index", out_word.match_index, want.match_index);
        end
        if (out_word.last_out !== want.last_out) begin
          report_mismatch("last_out", out_word.last_out, want.last_out);
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // size is 1 after reset, so the closer entry one must not win
  task automatic test_reset_size();
    send_word(load_word(CMD_TGT, 0, 0, 0, 0));
    send_word(load_word(CMD_TGT, 1, 4080, 4080, 4080));
    send_word(load_word(CMD_SRC, 0, 4080, 0, 2048));
    send_word(load_word(CMD_SRC, 1, 16, 32, 48));
    send_word(pixel_word(24'hffffff, 1'b1));
    send_word(pixel_word(24'h000000, 1'b0));
  endtask

  task automatic test_round_clamp();
    send_word(load_word(CMD_SRC, 0, -32768, 32767, -9));
    send_word(pixel_word(24'h123456, 1'b0));
    send_word(load_word(CMD_SRC, 0, -8, 7, 8));
    send_word(pixel_word(24'hfedcba, 1'b1));
    send_word(load_word(CMD_SRC, 0, 4071, 4072, 4088));
    send_word(pixel_word(24'h7f80ff, 1'b0));
  endtask

  task automatic test_zero_size();
    write_size(0);
    send_word(junk_word());
    send_word(pixel_word(24'ha5a5a5, 1'b1));
  endtask

  task automatic test_tie_break();
    write_size(4);
    send_word(load_word(CMD_SRC, 2, 800, 1600, 2400));
    send_word(load_word(CMD_SRC, 3, 3200, 400, 1200));
    send_word(load_word(CMD_TGT, 2, 0, 0, 0));
    send_word(load_word(CMD_TGT, 3, 0, 0, 0));
    send_word(pixel_word(24'h000000, 1'b0));
    send_word(load_word(CMD_TGT, 0, -32768, 32767, -1));
    send_word(pixel_word(24'h000000, 1'b1));
    send_word(load_word(CMD_TGT, 2, 32, 0, 0));
    send_word(pixel_word(24'h010000, 1'b0));
  endtask

  task automatic test_random(input int count, input int tx_pct, input int rx_pct,
                             input int size);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    write_size(size);
    repeat (count) send_word(rand_word());
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 10;
    write_size(16);
    rx_hold_left = 300;
    repeat (80) send_word(rand_word());
    wait_drain();
    repeat (60) send_word(rand_word());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size();
    test_round_clamp();
    test_zero_size();
    test_tie_break();
    test_random(250, 0, 0, 16);
    test_random(250, 86, 0, 31);
    test_random(250, 0, 86, 0);
    test_random(250, 17, 17, 1);
    test_random(250, 0, 0, 17);
    test_random(250, 17, 17, $urandom_range(2, 15));
    test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    wait_drain();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && remapped_q.size() == 0) begin
      $display("palette_nearest_color_remap_tb: PASS");
    end else begin
      $display("palette_nearest_color_remap_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: palette_nearest_color_remap.f
hw/rtl/pnc_pkg.sv
hw/rtl/pnc_dist.sv
hw/rtl/pnc_tree.sv
hw/rtl/pnc_remap.sv
hw/rtl/palette_nearest_color_remap.sv
verif/palette_nearest_color_remap_tb.sv
